### src/life_like_automaton_generation_unit_defines.svh
// Assertion macros used by the verification checker of the generation unit.
`ifndef LIFE_LIKE_AUTOMATON_GENERATION_UNIT_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_GENERATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lla_pkg.sv
// Shared types, constants and functions of the Life-like generation unit.
package lla_pkg;

    localparam int CFG_W    = 9;
    localparam int MIN_SIZE = 3;
    localparam int WIN_W    = 9;
    localparam int CNT_W    = 4;
    localparam int CENTRE   = 4;

    localparam logic [CFG_W-1:0] SURVIVE_RESET = 9'd12;
    localparam logic [CFG_W-1:0] BIRTH_RESET   = 9'd8;
    localparam logic [CFG_W-1:0] WIDTH_RESET   = 9'd256;
    localparam logic [CFG_W-1:0] HEIGHT_RESET  = 9'd144;

    // Keeps the left and centre columns after a one-column shift.
    localparam logic [WIN_W-1:0] SHIFT_KEEP = 9'h0DB;

    typedef enum logic [1:0] {
        CFG_SURVIVE = 2'd0,
        CFG_BIRTH   = 2'd1,
        CFG_WIDTH   = 2'd2,
        CFG_HEIGHT  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic first_col;
        logic row_ge1;
        logic row_ge2;
        logic lower_in;
        logic last_row;
    } item_ctl_t;

    function automatic logic [CNT_W-1:0] count_neighbours(input logic [WIN_W-1:0] win);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int b = 0; b < WIN_W; b++) begin
            if (b != CENTRE) begin
                n = n + CNT_W'(win[b]);
            end
        end
        return n;
    endfunction

endpackage

### src/lla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lla_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/lla_pos.sv
// Raster position counters and per-item row and column flags.
module lla_pos import lla_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    input  logic                         advance,
    input  logic [CFG_W-1:0]             grid_width,
    input  logic [CFG_W-1:0]             grid_height,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output item_ctl_t                    ctl
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int XW = (WW > CFG_W) ? WW : CFG_W;
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int XH = (RW > CFG_W) ? RW : CFG_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [XW-1:0] gw_ext;
    logic [XH-1:0] gh_ext;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [RW-1:0] h_plus1;
    logic [WW-1:0] col_inc;

    always_comb begin
        gw_ext = XW'(grid_width);
        gh_ext = XH'(grid_height);
        if (gw_ext < XW'(MIN_SIZE)) begin
            w_eff = WW'(MIN_SIZE);
        end else if (gw_ext > XW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(gw_ext);
        end
        if (gh_ext < XH'(MIN_SIZE)) begin
            h_eff = RW'(MIN_SIZE);
        end else if (gh_ext > XH'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(gh_ext);
        end
        h_plus1 = h_eff + RW'(1);
        col_inc = {1'b0, col_reg} + WW'(1);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (advance) begin
            if (row_reg >= h_plus1) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col           = col_reg;
    assign ctl.first_col = (col_reg == '0);
    assign ctl.row_ge1   = (row_reg != '0);
    assign ctl.row_ge2   = (row_reg >= RW'(2));
    assign ctl.lower_in  = (row_reg < h_eff);
    assign ctl.last_row  = (row_reg == h_plus1);

endmodule

### src/lla_window.sv
// Input stage, 3x3 neighbour window, rule lookup and result register.
module lla_window import lla_pkg::*; #(
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              cell_alive,
    input  item_ctl_t         item_ctl,
    input  logic [ADDR_W-1:0] item_col,
    input  logic [CFG_W-1:0]  survive_mask,
    input  logic [CFG_W-1:0]  birth_mask,
    input  logic [1:0]        line_rdata,
    output logic              line_we,
    output logic [ADDR_W-1:0] line_waddr,
    output logic [1:0]        line_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              next_alive,
    output logic              last_of_frame
);

    logic              stage_valid_reg, stage_valid_next;
    logic              cell_reg;
    item_ctl_t         ctl_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_alive_reg;
    logic              out_last_reg;

    logic              upper, middle, lower;
    logic [WIN_W-1:0]  column, shifted, judge_win;
    logic              produce, res_last, res_alive;
    logic [CNT_W-1:0]  count;
    logic              out_free, advance, accept;

    always_comb begin
        upper   = ctl_reg.row_ge2 & line_rdata[1];
        middle  = ctl_reg.row_ge1 & ~ctl_reg.last_row & line_rdata[0];
        lower   = ctl_reg.lower_in & cell_reg;
        column  = {lower, 2'b00, middle, 2'b00, upper, 2'b00};
        shifted = (win_reg >> 1) & SHIFT_KEEP;
        if (ctl_reg.first_col) begin
            judge_win = shifted;
            win_next  = column;
            produce   = ctl_reg.row_ge2;
            res_last  = ctl_reg.last_row;
        end else begin
            judge_win = shifted | column;
            win_next  = shifted | column;
            produce   = ctl_reg.row_ge1;
            res_last  = 1'b0;
        end
        count     = count_neighbours(judge_win);
        res_alive = judge_win[CENTRE] ? survive_mask[count] : birth_mask[count];
    end

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = stage_valid_reg && (out_free || !produce);
    assign s_ready  = aresetn && (!stage_valid_reg || advance);
    assign accept   = s_valid && s_ready;

    assign line_we    = advance;
    assign line_waddr = col_reg;
    assign line_wdata = {line_rdata[0], lower};

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && produce) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            win_reg         <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (advance) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cell_reg <= cell_alive;
            ctl_reg  <= item_ctl;
            col_reg  <= item_col;
        end
        if (advance && produce) begin
            out_alive_reg <= res_alive;
            out_last_reg  <= res_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign next_alive    = out_alive_reg;
    assign last_of_frame = out_last_reg;

endmodule

### src/life_like_automaton_generation_unit.sv
// Top level of the Life-like cellular automaton generation unit.
//
//   Channel  Direction  Handshake             Payload
//   s_       in         s_valid / s_ready     s_cell_alive
//   m_       out        m_valid / m_ready     m_next_alive, m_last_of_frame
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One cell transaction is accepted per cycle unless the input stage stalls; its
// result, if any, enters the result register when the cell leaves the input stage.
// The line store is one RAM read at acceptance and written when the cell leaves
// the input stage. The input stage stalls only when it holds a cell with a result
// and the result register is still occupied. Reset is synchronous and needs no
// clearing pass; no results appear for the first row and one cell of a frame.
module life_like_automaton_generation_unit import lla_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cell_alive,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_next_alive,
    output logic             m_last_of_frame,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] survive_reg, birth_reg, width_reg, height_reg;
    logic             cfg_write, restart, accept;
    logic [CW-1:0]    col;
    item_ctl_t        ctl;
    logic [1:0]       line_rdata, line_wdata;
    logic             line_we;
    logic [CW-1:0]    line_waddr;

    assign cfg_ready = aresetn;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = s_valid && s_ready;

    always_comb begin
        restart = 1'b0;
        case (cfg_reg_t'(cfg_index))
            CFG_WIDTH:  restart = cfg_write;
            CFG_HEIGHT: restart = cfg_write;
            default:    restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            survive_reg <= SURVIVE_RESET;
            birth_reg   <= BIRTH_RESET;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SURVIVE: survive_reg <= cfg_data;
                CFG_BIRTH:   birth_reg   <= cfg_data;
                CFG_WIDTH:   width_reg   <= cfg_data;
                CFG_HEIGHT:  height_reg  <= cfg_data;
                default:     survive_reg <= survive_reg;
            endcase
        end
    end

    lla_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (restart),
        .advance     (accept),
        .grid_width  (width_reg),
        .grid_height (height_reg),
        .col         (col),
        .ctl         (ctl)
    );

    lla_ram #(
        .DATA_W (2),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (line_rdata)
    );

    lla_window #(
        .ADDR_W (CW)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .cell_alive    (s_cell_alive),
        .item_ctl      (ctl),
        .item_col      (col),
        .survive_mask  (survive_reg),
        .birth_mask    (birth_reg),
        .line_rdata    (line_rdata),
        .line_we       (line_we),
        .line_waddr    (line_waddr),
        .line_wdata    (line_wdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .next_alive    (m_next_alive),
        .last_of_frame (m_last_of_frame)
    );

endmodule

### src/lla_checker.sv
// Port-level checker for the generation unit and its bind statement.
`include "life_like_automaton_generation_unit_defines.svh"

module lla_checker import lla_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_cell_alive,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_next_alive,
    input logic             m_last_of_frame,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [1:0]       cfg_index,
    input logic [CFG_W-1:0] cfg_data
);

    `LLA_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_next_alive) && $stable(m_last_of_frame), "Result changed or dropped while stalled.")

    `LLA_ASSERT_NEXT(a_reset_empties, aclk, 1'b1, !aresetn, !m_valid, "Result valid right after reset.")

    `LLA_ASSERT_NOW(a_result_follows_input, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2), "New result without a cell transaction two cycles earlier.")

    `LLA_ASSERT_NOW(a_cfg_always_ready, aclk, aresetn, cfg_valid, cfg_ready, "Configuration port not ready out of reset.")

endmodule

bind life_like_automaton_generation_unit lla_checker u_lla_checker (.*);
